### hdl/wlli_pkg.sv
// Shared types and constants for the wavetable LFO with linear interpolation.
// No dependencies; every other file refers to this package by scoped names.
`timescale 1ns / 1ps

package wlli_pkg;

    // Fixed field widths of the channels and the configuration port
    localparam int IDX_W      = 9;
    localparam int SMP_W      = 16;
    localparam int PHASE_W    = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    // Item modes
    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_TICK  = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_INC = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DC_OFFSET = 1'b1;

    localparam logic [SMP_W-1:0] DC_OFFSET_RST = 16'h4000;

    // Decoupling queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

### hdl/wlli_in_if.sv
// Input channel of the wavetable LFO: table writes and sample ticks.
// Depends on wlli_pkg for the field widths.
`timescale 1ns / 1ps

interface wlli_in_if;
    logic                              valid;
    logic                              ready;
    logic                              mode;
    logic [wlli_pkg::IDX_W-1:0]        table_index;
    logic signed [wlli_pkg::SMP_W-1:0] table_value;

    modport source (output valid, output mode, output table_index, output table_value,
                    input ready);
    modport sink   (input valid, input mode, input table_index, input table_value,
                    output ready);
endinterface

### hdl/wlli_out_if.sv
// Output channel of the wavetable LFO: one oscillator sample per tick.
// Depends on wlli_pkg for the sample width.
`timescale 1ns / 1ps

interface wlli_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [wlli_pkg::SMP_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

### hdl/wlli_front.sv
// Front end: accepts items, advances the phase accumulator on ticks and packs
// each item into a queue entry. Depends on wlli_pkg and wlli_in_if.
`timescale 1ns / 1ps

module wlli_front #(
    parameter int TABLE_ADDR_BITS = 9,
    parameter int FRAC_BITS       = 23,
    parameter int PAY_W           = 23,
    parameter int ENT_W           = 33
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  wlli_pkg::t_cfg_wr    i_cfg,
    wlli_in_if.sink              i_item,
    input  wlli_pkg::t_q_stat    i_q_stat,
    output logic                 o_push,
    output logic [ENT_W-1:0]     o_entry
);

    logic [wlli_pkg::PHASE_W-1:0]                 r_phase_inc;
    logic [wlli_pkg::PHASE_W-1:0]                 n_phase_inc;
    logic [wlli_pkg::PHASE_W-1:0]                 r_phase;
    logic [wlli_pkg::PHASE_W-1:0]                 n_phase;
    logic [wlli_pkg::PHASE_W-1:0]                 phase_sum;
    logic [wlli_pkg::PHASE_W+TABLE_ADDR_BITS-1:0] phase_ext;
    logic [wlli_pkg::IDX_W+TABLE_ADDR_BITS-1:0]   widx_ext;
    logic [TABLE_ADDR_BITS-1:0]                   entry_addr;
    logic [PAY_W-1:0]                             entry_pay;
    logic                                         is_tick;

    assign i_item.ready = !i_q_stat.full;
    assign o_push       = i_item.valid && i_item.ready;
    assign is_tick      = (i_item.mode == wlli_pkg::MODE_TICK);

    assign phase_sum = r_phase + r_phase_inc;
    // Zero-extend so the index select stays in range for any split of the phase
    assign phase_ext = {{TABLE_ADDR_BITS{1'b0}}, phase_sum};
    assign widx_ext  = {{TABLE_ADDR_BITS{1'b0}}, i_item.table_index};

    always_comb begin
        if (is_tick) begin
            entry_addr = phase_ext[FRAC_BITS +: TABLE_ADDR_BITS];
            entry_pay  = PAY_W'(phase_sum[FRAC_BITS-1:0]);
        end else begin
            entry_addr = widx_ext[TABLE_ADDR_BITS-1:0];
            entry_pay  = PAY_W'($unsigned(i_item.table_value));
        end
    end

    assign o_entry = {i_item.mode, entry_addr, entry_pay};

    always_comb begin
        n_phase_inc = r_phase_inc;
        if (i_cfg.we) begin
            unique case (i_cfg.idx)
                wlli_pkg::CFG_PHASE_INC: n_phase_inc = i_cfg.data;
                default: ;
            endcase
        end
    end

    // Advance the accumulator only on an accepted tick
    assign n_phase = (o_push && is_tick) ? phase_sum : r_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_inc <= '0;
            r_phase     <= '0;
        end else begin
            r_phase_inc <= n_phase_inc;
            r_phase     <= n_phase;
        end
    end

endmodule

### hdl/wlli_queue.sv
// Short decoupling queue between the front end and the back end.
// Depends on wlli_pkg for its depth and status type.
`timescale 1ns / 1ps

module wlli_queue #(
    parameter int ENT_W = 33
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [ENT_W-1:0]  i_entry,
    input  logic              i_pop,
    output logic [ENT_W-1:0]  o_head,
    output wlli_pkg::t_q_stat o_stat
);

    logic [ENT_W-1:0]             r_slot [wlli_pkg::Q_DEPTH];
    logic [wlli_pkg::Q_PTR_W-1:0] r_wptr;
    logic [wlli_pkg::Q_PTR_W-1:0] r_rptr;
    logic [wlli_pkg::Q_CNT_W-1:0] r_count;
    logic [wlli_pkg::Q_CNT_W-1:0] n_count;

    assign o_stat.full  = (r_count == wlli_pkg::Q_CNT_W'(wlli_pkg::Q_DEPTH));
    assign o_stat.empty = (r_count == '0);
    assign o_head       = r_slot[r_rptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    a_no_overfill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= wlli_pkg::Q_CNT_W'(wlli_pkg::Q_DEPTH))
        else $error("queue holds more entries than its depth");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> r_count != '0)
        else $error("queue popped while empty");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("queue count missed a push");

endmodule

### hdl/wlli_back.sv
// Back end: wave table, interpolation multiply and output register.
// Depends on wlli_pkg and wlli_out_if; fed from wlli_queue.
`timescale 1ns / 1ps

module wlli_back #(
    parameter int TABLE_ADDR_BITS = 9,
    parameter int FRAC_BITS       = 23,
    parameter int PAY_W           = 23,
    parameter int ENT_W           = 33
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  wlli_pkg::t_cfg_wr i_cfg,
    input  logic [ENT_W-1:0]  i_head,
    input  wlli_pkg::t_q_stat i_q_stat,
    output logic              o_pop,
    wlli_out_if.source        o_result
);

    localparam int TABLE_SIZE = 1 << TABLE_ADDR_BITS;
    localparam int DIFF_W     = wlli_pkg::SMP_W + 1;
    localparam int PROD_W     = DIFF_W + FRAC_BITS + 1;
    localparam int SUM_W      = wlli_pkg::SMP_W + 2;

    logic [wlli_pkg::SMP_W-1:0]        r_wave [TABLE_SIZE];

    logic                              head_tick;
    logic [TABLE_ADDR_BITS-1:0]        head_addr;
    logic [TABLE_ADDR_BITS-1:0]        head_next;
    logic [PAY_W-1:0]                  head_pay;
    logic                              en0;
    logic                              en1;
    logic                              en2;

    logic                              r_b0_valid;
    logic signed [wlli_pkg::SMP_W-1:0] r_y0;
    logic signed [wlli_pkg::SMP_W-1:0] r_y1;
    logic [FRAC_BITS-1:0]              r_b0_frac;

    logic                              r_b1_valid;
    logic signed [PROD_W-1:0]          r_prod;
    logic signed [wlli_pkg::SMP_W-1:0] r_b1_y0;
    logic signed [DIFF_W-1:0]          diff;

    logic                              r_out_valid;
    logic [wlli_pkg::SMP_W-1:0]        r_sample;
    logic [wlli_pkg::SMP_W-1:0]        n_sample;
    logic [wlli_pkg::SMP_W-1:0]        r_dc_offset;
    logic [wlli_pkg::SMP_W-1:0]        n_dc_offset;
    logic signed [PROD_W-1:0]          prod_sh;
    logic signed [SUM_W-1:0]           interp;
    logic signed [SUM_W-1:0]           halved;

    assign head_tick = (i_head[ENT_W-1] == wlli_pkg::MODE_TICK);
    assign head_addr = i_head[PAY_W +: TABLE_ADDR_BITS];
    assign head_next = head_addr + 1'b1;
    assign head_pay  = i_head[PAY_W-1:0];

    // Each stage moves when the one after it is empty or moving
    assign en2   = !r_out_valid || o_result.ready;
    assign en1   = !r_b1_valid || en2;
    assign en0   = !r_b0_valid || en1;
    // Writes retire straight into the table; ticks need room in the first stage
    assign o_pop = !i_q_stat.empty && (!head_tick || en0);

    always_ff @(posedge i_clk) begin
        if (o_pop && !head_tick) begin
            r_wave[head_addr] <= head_pay[wlli_pkg::SMP_W-1:0];
        end
        if (o_pop && head_tick) begin
            r_y0      <= r_wave[head_addr];
            r_y1      <= r_wave[head_next];
            r_b0_frac <= head_pay[FRAC_BITS-1:0];
        end
    end

    assign diff = {r_y1[wlli_pkg::SMP_W-1], r_y1} - {r_y0[wlli_pkg::SMP_W-1], r_y0};

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_prod  <= diff * $signed({1'b0, r_b0_frac});
            r_b1_y0 <= r_y0;
        end
    end

    // Floor shift of the product, add the base sample, halve, then offset
    assign prod_sh  = r_prod >>> FRAC_BITS;
    assign interp   = $signed(prod_sh[SUM_W-1:0])
                    + $signed({{2{r_b1_y0[wlli_pkg::SMP_W-1]}}, r_b1_y0});
    assign halved   = interp >>> 1;
    assign n_sample = halved[wlli_pkg::SMP_W-1:0] + r_dc_offset;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_sample <= n_sample;
        end
    end

    always_comb begin
        n_dc_offset = r_dc_offset;
        if (i_cfg.we) begin
            unique case (i_cfg.idx)
                wlli_pkg::CFG_DC_OFFSET: n_dc_offset = i_cfg.data[wlli_pkg::SMP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0_valid  <= 1'b0;
            r_b1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_dc_offset <= wlli_pkg::DC_OFFSET_RST;
        end else begin
            if (en0) begin
                r_b0_valid <= o_pop && head_tick;
            end
            if (en1) begin
                r_b1_valid <= r_b0_valid;
            end
            if (en2) begin
                r_out_valid <= r_b1_valid;
            end
            r_dc_offset <= n_dc_offset;
        end
    end

    assign o_result.valid  = r_out_valid;
    assign o_result.sample = r_sample;

    a_tick_reaches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en2 && r_b1_valid) |=> r_out_valid)
        else $error("interpolated tick lost before the output register");

    a_stall_holds_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b1_valid && !en1) |=> (r_b1_valid && $stable(r_prod)))
        else $error("product stage changed while stalled");

    a_pop_only_with_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pop && head_tick) |-> en0)
        else $error("tick taken from queue without room in the read stage");

endmodule

### hdl/wavetable_lfo_linear_interp.sv
// Wavetable LFO: 2^TABLE_ADDR_BITS-entry table of signed 16-bit samples, a
// 32-bit phase accumulator and linear interpolation between adjacent entries.
// Takes one item per clock while the queue has room, table write or tick
// alike, and passes a tick through a queue slot, table read, multiply and
// output register in turn. The rate is set by the table, which serves one
// write or one pair of reads each cycle. A four-entry queue parts the front
// end from the back end, so input ready falls only once four items wait
// behind a stalled output. Entries must be written before a tick reads them.
// Registers: index 0 is phase_increment, index 1 is dc_offset.
`timescale 1ns / 1ps

module wavetable_lfo_linear_interp #(
    parameter int TABLE_ADDR_BITS = 9,
    parameter int FRAC_BITS       = 23
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [wlli_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [wlli_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    wlli_in_if.sink                           i_item,
    wlli_out_if.source                        o_result
);

    localparam int PAY_W = (FRAC_BITS > wlli_pkg::SMP_W) ? FRAC_BITS : wlli_pkg::SMP_W;
    localparam int ENT_W = 1 + TABLE_ADDR_BITS + PAY_W;

    wlli_pkg::t_cfg_wr cfg;
    wlli_pkg::t_q_stat q_stat;
    logic              push;
    logic              pop;
    logic [ENT_W-1:0]  entry;
    logic [ENT_W-1:0]  head;

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    wlli_front #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .FRAC_BITS       (FRAC_BITS),
        .PAY_W           (PAY_W),
        .ENT_W           (ENT_W)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_item   (i_item),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_entry  (entry)
    );

    wlli_queue #(
        .ENT_W (ENT_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (entry),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    wlli_back #(
        .TABLE_ADDR_BITS (TABLE_ADDR_BITS),
        .FRAC_BITS       (FRAC_BITS),
        .PAY_W           (PAY_W),
        .ENT_W           (ENT_W)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_head   (head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_result (o_result)
    );

endmodule
